[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with delete by value.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;

  // Command codes
  localparam logic [3:0] ACT_ADD_FRONT  = 4'd0;
  localparam logic [3:0] ACT_ADD_BACK   = 4'd1;
  localparam logic [3:0] ACT_REM_FRONT  = 4'd2;
  localparam logic [3:0] ACT_REM_BACK   = 4'd3;
  localparam logic [3:0] ACT_REM_VALUE  = 4'd4;
  localparam logic [3:0] ACT_READ_ALL   = 4'd5;
  localparam logic [3:0] ACT_READ_FIRST = 4'd6;
  localparam logic [3:0] ACT_READ_LAST  = 4'd7;
  localparam logic [3:0] ACT_CLEAR      = 4'd8;

  // Result status codes
  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [3:0]                 action;
    logic signed [VALUE_W-1:0]  value;
    logic [6:0]                 count;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  item_value;
    logic [1:0]                 status;
    logic                       last;
  } out_t;

endpackage

[rtl/bounded_deque_with_value_delete.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete
// Bounded deque of signed 32-bit entries in a circular RAM, with readouts
// and removal of every copy of a value.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  input   | in_valid / in_ready     | in_data  : action, value, count
//  output  | out_valid / out_ready   | out_data : item_value, status, last
//
//  Add, remove front/back and clear update the deque when accepted; full and
//  empty reports are registered. Readout issues one RAM read per cycle while
//  the output is not stalled. Remove value walks the entries with the read
//  port while the write port compacts the survivors.
//  The block takes a new item only when idle and the output register is free.
//  Reset (rst, synchronous) empties the deque; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bdq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bdq_pkg::out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_DELETE = 2'd2;

  logic [1:0]                         state;
  logic [AW-1:0]                      front_idx;
  logic [CW-1:0]                      entry_cnt;
  logic [AW-1:0]                      rd_ptr;
  logic [AW-1:0]                      wr_ptr;
  logic [CW-1:0]                      issue_left;
  logic [CW-1:0]                      load_left;
  logic [CW-1:0]                      kept;
  logic                               pending;
  logic signed [bdq_pkg::VALUE_W-1:0] match_val;

  logic                               can_load;
  logic                               accept;
  logic                               full;
  logic                               issue;
  logic                               keep;
  logic [AW-1:0]                      front_dec;
  logic [AW-1:0]                      back_slot;
  logic [CW-1:0]                      read_n;
  logic [AW-1:0]                      read_start;

  logic                               ram_wr_en;
  logic [AW-1:0]                      ram_wr_addr;
  logic [bdq_pkg::VALUE_W-1:0]        ram_wr_data;
  logic [bdq_pkg::VALUE_W-1:0]        ram_rd_data;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign can_load  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && can_load;
  assign accept    = in_valid && in_ready;
  assign full      = (entry_cnt == CW'(DEPTH));
  assign front_dec = (front_idx == '0) ? AW'(DEPTH - 1) : front_idx - 1'b1;
  assign back_slot = slot_of(front_idx, entry_cnt);
  assign keep      = pending && (ram_rd_data != match_val);

  always_comb begin
    if (in_data.action == bdq_pkg::ACT_READ_ALL) begin
      read_n = entry_cnt;
    end else if (in_data.count > 7'(entry_cnt)) begin
      read_n = entry_cnt;
    end else begin
      read_n = in_data.count[CW-1:0];
    end
  end

  assign read_start = (in_data.action == bdq_pkg::ACT_READ_LAST) ?
                      slot_of(front_idx, entry_cnt - read_n) : front_idx;

  // a read slot frees up when the previous data is loaded this cycle
  always_comb begin
    issue = 1'b0;
    if (state == ST_READ) begin
      issue = (issue_left != '0) && (!pending || can_load);
    end else if (state == ST_DELETE) begin
      issue = (issue_left != '0);
    end
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = wr_ptr;
    ram_wr_data = ram_rd_data;
    if (state == ST_DELETE) begin
      ram_wr_en = keep;
    end else if (accept && !full &&
                 (in_data.action == bdq_pkg::ACT_ADD_FRONT ||
                  in_data.action == bdq_pkg::ACT_ADD_BACK)) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = (in_data.action == bdq_pkg::ACT_ADD_FRONT) ? front_dec : back_slot;
      ram_wr_data = in_data.value;
    end
  end

  bdq_ram #(
    .WIDTH (bdq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (issue),
    .rd_addr (rd_ptr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front_idx <= '0;
      entry_cnt <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.action)
              bdq_pkg::ACT_ADD_FRONT, bdq_pkg::ACT_ADD_BACK: begin
                if (full) begin
                  out_valid           <= 1'b1;
                  out_data.item_value <= '0;
                  out_data.status     <= bdq_pkg::STATUS_FULL;
                  out_data.last       <= 1'b1;
                end else begin
                  entry_cnt <= entry_cnt + 1'b1;
                  if (in_data.action == bdq_pkg::ACT_ADD_FRONT) begin
                    front_idx <= front_dec;
                  end
                end
              end
              bdq_pkg::ACT_REM_FRONT: begin
                if (entry_cnt != '0) begin
                  front_idx <= ptr_inc(front_idx);
                  entry_cnt <= entry_cnt - 1'b1;
                end
              end
              bdq_pkg::ACT_REM_BACK: begin
                if (entry_cnt != '0) begin
                  entry_cnt <= entry_cnt - 1'b1;
                end
              end
              bdq_pkg::ACT_REM_VALUE: begin
                if (entry_cnt != '0) begin
                  state      <= ST_DELETE;
                  rd_ptr     <= front_idx;
                  wr_ptr     <= front_idx;
                  issue_left <= entry_cnt;
                  kept       <= '0;
                  match_val  <= in_data.value;
                  pending    <= 1'b0;
                end
              end
              bdq_pkg::ACT_READ_ALL, bdq_pkg::ACT_READ_FIRST,
              bdq_pkg::ACT_READ_LAST: begin
                if (read_n == '0) begin
                  out_valid           <= 1'b1;
                  out_data.item_value <= '0;
                  out_data.status     <= bdq_pkg::STATUS_EMPTY;
                  out_data.last       <= 1'b1;
                end else begin
                  state      <= ST_READ;
                  rd_ptr     <= read_start;
                  issue_left <= read_n;
                  load_left  <= read_n;
                  pending    <= 1'b0;
                end
              end
              bdq_pkg::ACT_CLEAR: begin
                entry_cnt <= '0;
                front_idx <= '0;
              end
              default: begin
                // unused codes: drop the item
              end
            endcase
          end
        end
        ST_READ: begin
          if (issue) begin
            rd_ptr     <= ptr_inc(rd_ptr);
            issue_left <= issue_left - 1'b1;
          end
          pending <= issue || (pending && !can_load);
          if (pending && can_load) begin
            out_valid           <= 1'b1;
            out_data.item_value <= ram_rd_data;
            out_data.status     <= bdq_pkg::STATUS_DATA;
            out_data.last       <= (load_left == CW'(1));
            load_left           <= load_left - 1'b1;
            if (load_left == CW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DELETE: begin
          if (issue) begin
            rd_ptr     <= ptr_inc(rd_ptr);
            issue_left <= issue_left - 1'b1;
          end
          pending <= issue;
          if (keep) begin
            wr_ptr <= ptr_inc(wr_ptr);
            kept   <= kept + 1'b1;
          end
          // last compare: commit the compacted length
          if (pending && issue_left == '0) begin
            entry_cnt <= kept + CW'(keep);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Assertions

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    entry_cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (state == ST_IDLE && entry_cnt == '0 && !out_valid))
    else $error("deque not empty after reset");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != bdq_pkg::STATUS_DATA) |->
      (out_data.last && out_data.item_value == '0))
    else $error("status result without last mark or with nonzero value");

  a_read_balance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (issue_left + CW'(pending) == load_left))
    else $error("readout reads and loads out of step");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELETE) |-> (kept <= entry_cnt))
    else $error("compaction kept more entries than stored");

endmodule

[rtl/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
